>>> design/multi_header_frame_receiver_crc16_core_assert.svh
// Assertion macros for the frame receiver core.
`ifndef MULTI_HEADER_FRAME_RECEIVER_CRC16_CORE_ASSERT_SVH
`define MULTI_HEADER_FRAME_RECEIVER_CRC16_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHFR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/mhfr_pkg.sv
// Types, constants and functions for the framed packet receiver.
package mhfr_pkg;

   localparam int KIND_COUNT = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0]  DEVICE_ID_RESET = 8'd128;
   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [3:0]  HEADER_LEN = 4'd4;

   localparam logic [31:0] HEADER_WORD [KIND_COUNT] = '{
      32'hBEBAADAB, 32'h0DF005B1, 32'hB5006BB1
   };
   localparam logic [3:0] FRAME_LEN [KIND_COUNT] = '{4'd7, 4'd14, 4'd11};

   typedef enum logic [1:0] {
      KIND_STATUS_REQ = 2'd0,
      KIND_HAND_CMD   = 2'd1,
      KIND_CONTROL    = 2'd2
   } frame_kind_type;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED  = 2'd0,
      STATUS_CRC_ERROR = 2'd1,
      STATUS_OTHER_ID  = 2'd2
   } frame_status_type;

   // One queue entry holds every completion caused by one received byte.
   typedef struct packed {
      logic [KIND_COUNT-1:0]      hit;
      logic [KIND_COUNT-1:0][1:0] status;
   } qentry_type;

   // Header byte at position sel, low byte first.
   function automatic logic [7:0] header_byte(logic [31:0] word, logic [1:0] sel);
      logic [31:0] shifted;
      shifted = word >> {sel, 3'b000};
      return shifted[7:0];
   endfunction

   // One byte of CRC-16, MSB first, no reflection.
   function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] data);
      logic [15:0] c;
      c = acc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> design/multi_header_frame_receiver_crc16_core.sv
// Top level of the framed packet receiver with CRC-16 check.
//
// Usage: received bytes enter on the req_ channel (req_valid/req_ready,
// req_rx_byte). Three matchers, one per frame kind, update on every
// accepted byte. A byte that ends one or more frames produces one result
// per ended frame on the rsp_ channel, in kind order, with rsp_last_of_run
// set on the last result of that byte. Bytes that end no frame give nothing.
// Throughput: one byte per cycle while the result queue is not full; a byte
// that ends k frames occupies the result port for k results. The per-byte
// work is a header compare and a one-byte CRC update per matcher, all
// combinational and registered into the result queue with the byte.
// The result queue holds QueueDepth bytes' worth of results; req_ready is low
// only while it is full, so a stalled receiver backs up into the byte stream.
// Reset: all matchers restart, device_id returns to 128, the queue empties.
// The device_id register sits at address 0 of the APB-style port.
`include "multi_header_frame_receiver_crc16_core_assert.svh"

module multi_header_frame_receiver_crc16_core #(
   parameter int QueueDepth = mhfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_kind,
   output logic [1:0]  rsp_frame_status,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int K = mhfr_pkg::KIND_COUNT;
   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic REG_DEVICE_ID = 1'b0;

   // Configuration
   logic [7:0] device_id_ff;
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_DEVICE_ID) ? {24'd0, device_id_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= mhfr_pkg::DEVICE_ID_RESET;
      end else if (cfg_write && paddr[2] == REG_DEVICE_ID) begin
         device_id_ff <= pwdata[7:0];
      end
   end

   // Matcher state
   logic [3:0]  pos_ff   [K];
   logic [3:0]  pos_in   [K];
   logic        body_ff  [K];
   logic        body_in  [K];
   logic [15:0] crc_ff   [K];
   logic [15:0] crc_in   [K];
   logic [7:0]  first_ff [K];
   logic [7:0]  first_in [K];
   logic        idok_ff  [K];
   logic        idok_in  [K];

   logic                   req_fire;
   mhfr_pkg::qentry_type   new_entry;

   assign req_fire = req_valid && req_ready;

   always_comb begin
      logic [7:0] want;
      new_entry = '0;
      want = 8'd0;
      for (int i = 0; i < K; i++) begin
         pos_in[i]   = pos_ff[i];
         body_in[i]  = body_ff[i];
         crc_in[i]   = crc_ff[i];
         first_in[i] = first_ff[i];
         idok_in[i]  = idok_ff[i];
         if (!body_ff[i]) begin
            want = mhfr_pkg::header_byte(mhfr_pkg::HEADER_WORD[i], pos_ff[i][1:0]);
            if (pos_ff[i] < mhfr_pkg::HEADER_LEN && req_rx_byte == want) begin
               pos_in[i] = pos_ff[i] + 4'd1;
               if (pos_in[i] == mhfr_pkg::HEADER_LEN) begin
                  body_in[i] = 1'b1;
               end
            end else begin
               pos_in[i] = 4'd0;
            end
         end else begin
            if (pos_ff[i] == mhfr_pkg::HEADER_LEN) begin
               idok_in[i] = (req_rx_byte == device_id_ff);
            end
            if ({1'b0, pos_ff[i]} + 5'd2 < {1'b0, mhfr_pkg::FRAME_LEN[i]}) begin
               crc_in[i] = mhfr_pkg::crc16_update(crc_ff[i], req_rx_byte);
               pos_in[i] = pos_ff[i] + 4'd1;
            end else if ({1'b0, pos_ff[i]} + 5'd2 == {1'b0, mhfr_pkg::FRAME_LEN[i]}) begin
               first_in[i] = req_rx_byte;
               pos_in[i]   = pos_ff[i] + 4'd1;
            end else begin
               // Last byte of the frame: judge it and restart the matcher.
               new_entry.hit[i] = 1'b1;
               if (!idok_ff[i]) begin
                  new_entry.status[i] = mhfr_pkg::STATUS_OTHER_ID;
               end else if (first_ff[i] == crc_ff[i][15:8] && req_rx_byte == crc_ff[i][7:0]) begin
                  new_entry.status[i] = mhfr_pkg::STATUS_ACCEPTED;
               end else begin
                  new_entry.status[i] = mhfr_pkg::STATUS_CRC_ERROR;
               end
               pos_in[i]  = 4'd0;
               body_in[i] = 1'b0;
               crc_in[i]  = mhfr_pkg::CRC_INIT;
               idok_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < K; i++) begin
         if (reset) begin
            pos_ff[i]  <= 4'd0;
            body_ff[i] <= 1'b0;
            crc_ff[i]  <= mhfr_pkg::CRC_INIT;
            idok_ff[i] <= 1'b0;
         end else if (req_fire) begin
            pos_ff[i]  <= pos_in[i];
            body_ff[i] <= body_in[i];
            crc_ff[i]  <= crc_in[i];
            idok_ff[i] <= idok_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < K; i++) begin
            first_ff[i] <= first_in[i];
         end
      end
   end

   // Result queue: one entry per byte that ended at least one frame.
   mhfr_pkg::qentry_type   queue_mem [QueueDepth];
   logic [PtrW-1:0]        wr_ptr_ff;
   logic [PtrW-1:0]        rd_ptr_ff;
   logic [CntW-1:0]        count_ff;
   logic [K-1:0]           done_ff;
   logic [K-1:0]           head_left;
   logic [K-1:0]           head_rest;
   mhfr_pkg::qentry_type   head;
   mhfr_pkg::frame_kind_type head_kind;
   logic                   push;
   logic                   pop;
   logic                   rsp_fire;

   assign req_ready = (count_ff != CntW'(QueueDepth));
   assign push      = req_fire && (new_entry.hit != '0);
   assign head      = queue_mem[rd_ptr_ff];
   assign head_left = head.hit & ~done_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      if (head_left[0]) begin
         head_kind = mhfr_pkg::KIND_STATUS_REQ;
      end else if (head_left[1]) begin
         head_kind = mhfr_pkg::KIND_HAND_CMD;
      end else begin
         head_kind = mhfr_pkg::KIND_CONTROL;
      end
      head_rest = head_left & ~(K'(1) << head_kind);
   end

   assign rsp_frame_kind   = head_kind;
   assign rsp_frame_status = head.status[head_kind];
   assign rsp_last_of_run  = (head_rest == '0);
   assign pop              = rsp_fire && rsp_last_of_run;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         done_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
            done_ff   <= '0;
         end else if (rsp_fire) begin
            done_ff <= done_ff | (K'(1) << head_kind);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

   `MHFR_ASSERT_SAME(a_head_not_empty, rsp_valid, head_left != '0,
      "Result queue head holds no pending result.")
   `MHFR_ASSERT_NEXT(a_run_continues, rsp_fire && !rsp_last_of_run, rsp_valid,
      "Result run ended before its last result.")
   `MHFR_ASSERT_SAME(a_body_after_header, 1'b1,
      (body_ff[0] == (pos_ff[0] >= mhfr_pkg::HEADER_LEN)) &&
      (body_ff[1] == (pos_ff[1] >= mhfr_pkg::HEADER_LEN)) &&
      (body_ff[2] == (pos_ff[2] >= mhfr_pkg::HEADER_LEN)),
      "Matcher body flag disagrees with its position.")
   `MHFR_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CntW'(QueueDepth),
      "Result queue count exceeds its depth.")

endmodule

>>> tb/sv/tb_multi_header_frame_receiver_crc16_core.sv
// Self-checking testbench for the three-header CRC-16 frame receiver core.
`timescale 1ns / 100ps

module tb_multi_header_frame_receiver_crc16_core;

   localparam int          ITEM_TARGET    = 330;
   localparam int          MIX_BYTES      = 40;
   localparam int          HOLD_CYCLES    = 120;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam logic [2:0]  ADDR_DEVICE_ID = 3'd0;
   localparam logic [2:0]  ADDR_UNMAPPED  = 3'd4;

   typedef struct {
      mhfr_pkg::frame_kind_type   kind;
      mhfr_pkg::frame_status_type status;
      logic                       last;
   } frame_result_type;

   typedef logic [7:0] byte_list_type [$];

   // Tracks the three header matchers and the frame completions they should produce.
   class frame_scoreboard;
      logic [7:0]       device_id;
      int               position [mhfr_pkg::KIND_COUNT];
      bit               in_body [mhfr_pkg::KIND_COUNT];
      logic [15:0]      crc_acc [mhfr_pkg::KIND_COUNT];
      logic [7:0]       crc_high_seen [mhfr_pkg::KIND_COUNT];
      bit               id_ok [mhfr_pkg::KIND_COUNT];
      frame_result_type pending_results [$];
      int               error_count;

      function new();
         device_id = mhfr_pkg::DEVICE_ID_RESET;
         for (int k = 0; k < mhfr_pkg::KIND_COUNT; k++) begin
            restart(k);
            crc_high_seen[k] = 8'h00;
         end
         error_count = 0;
      endfunction

      function void restart(int k);
         position[k] = 0;
         in_body[k] = 1'b0;
         crc_acc[k] = mhfr_pkg::CRC_INIT;
         id_ok[k] = 1'b0;
      endfunction

      // Bitwise form: feedback is the top CRC bit xored with the next data bit.
      static function logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] data);
         logic [15:0] c;
         bit          fb;
         c = acc;
         for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ data[k];
            c = {c[14:0], 1'b0};
            if (fb) begin
               c = c ^ mhfr_pkg::CRC_POLY;
            end
         end
         return c;
      endfunction

      function void write_register(int index, logic [31:0] value);
         if (index == 0) begin
            device_id = value[7:0];
         end
      endfunction

      function void note_byte(logic [7:0] b);
         frame_result_type done [$];
         frame_result_type r;
         logic [31:0]      hdr;
         int               pos;
         int               len;
         for (int k = 0; k < mhfr_pkg::KIND_COUNT; k++) begin
            pos = position[k];
            len = mhfr_pkg::FRAME_LEN[k];
            if (!in_body[k]) begin
               hdr = mhfr_pkg::HEADER_WORD[k];
               // A mismatching byte is not retried as the start of a new header.
               if (pos < mhfr_pkg::HEADER_LEN && b == hdr[8*(pos%4) +: 8]) begin
                  position[k] = pos + 1;
                  if (pos + 1 == mhfr_pkg::HEADER_LEN) begin
                     in_body[k] = 1'b1;
                  end
               end else begin
                  position[k] = 0;
               end
            end else begin
               if (pos == mhfr_pkg::HEADER_LEN) begin
                  id_ok[k] = (b == device_id);
               end
               if (pos + 2 < len) begin
                  crc_acc[k] = crc_byte(crc_acc[k], b);
                  position[k] = pos + 1;
               end else if (pos + 2 == len) begin
                  crc_high_seen[k] = b;
                  position[k] = pos + 1;
               end else begin
                  r.kind = mhfr_pkg::frame_kind_type'(k);
                  if (!id_ok[k]) begin
                     r.status = mhfr_pkg::STATUS_OTHER_ID;
                  end else if (crc_high_seen[k] == crc_acc[k][15:8] &&
                               b == crc_acc[k][7:0]) begin
                     r.status = mhfr_pkg::STATUS_ACCEPTED;
                  end else begin
                     r.status = mhfr_pkg::STATUS_CRC_ERROR;
                  end
                  r.last = 1'b0;
                  done.push_back(r);
                  restart(k);
               end
            end
         end
         if (done.size() > 0) begin
            done[done.size()-1].last = 1'b1;
         end
         foreach (done[j]) begin
            pending_results.push_back(done[j]);
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [1:0] status, logic last);
         frame_result_type want;
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: kind %0d status %0d last %0b",
                     $time, kind, status, last);
            return;
         end
         want = pending_results.pop_front();
         if (kind !== want.kind) begin
            error_count++;
            $display("%0t: frame_kind expected %0d, got %0d", $time, want.kind, kind);
         end
         if (status !== want.status) begin
            error_count++;
            $display("%0t: frame_status expected %0d, got %0d",
                     $time, want.status, status);
         end
         if (last !== want.last) begin
            error_count++;
            $display("%0t: last_of_run expected %0b, got %0b", $time, want.last, last);
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_frame_kind;
   logic [1:0]  rsp_frame_status;
   logic        rsp_last_of_run;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   frame_scoreboard sb;
   byte_list_type   frame_buf;
   int              bytes_sent = 0;
   int              quiet_cycles = 0;
   bit              sender_idle_on = 1'b0;
   bit              sink_idle_on = 1'b0;
   bit              hold_off_request = 1'b0;

   multi_header_frame_receiver_crc16_core uut (.*);

   always #4 clock = ~clock;

   function automatic byte_list_type random_payload(int n);
      byte_list_type p;
      repeat (n) p.push_back(8'($urandom_range(0, 255)));
      return p;
   endfunction

   function automatic void append_frame(int kind, logic [7:0] id, byte_list_type payload,
                                        bit bad_crc);
      logic [31:0] hdr;
      logic [15:0] crc;
      hdr = mhfr_pkg::HEADER_WORD[kind];
      for (int j = 0; j < 4; j++) begin
         frame_buf.push_back(hdr[8*j +: 8]);
      end
      frame_buf.push_back(id);
      crc = frame_scoreboard::crc_byte(mhfr_pkg::CRC_INIT, id);
      foreach (payload[j]) begin
         frame_buf.push_back(payload[j]);
         crc = frame_scoreboard::crc_byte(crc, payload[j]);
      end
      if (bad_crc) begin
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      end
      frame_buf.push_back(crc[15:8]);
      frame_buf.push_back(crc[7:0]);
   endfunction

   // A status request frame nested inside a longer frame so that both end on the
   // same byte; the shared CRC bytes suit one of the two frames.
   function automatic void append_overlap();
      logic [31:0]   hdr0;
      logic [7:0]    id0;
      logic [15:0]   crc0;
      byte_list_type p;
      int            n;
      hdr0 = mhfr_pkg::HEADER_WORD[mhfr_pkg::KIND_STATUS_REQ];
      id0 = $urandom_range(0, 1) ? sb.device_id : 8'($urandom_range(0, 255));
      crc0 = frame_scoreboard::crc_byte(mhfr_pkg::CRC_INIT, id0);
      if ($urandom_range(0, 1)) begin
         p = random_payload(2);
         for (int j = 0; j < 4; j++) begin
            p.push_back(hdr0[8*j +: 8]);
         end
         p.push_back(id0);
         append_frame(mhfr_pkg::KIND_HAND_CMD, sb.device_id, p, 1'b0);
      end else begin
         for (int j = 1; j < 4; j++) begin
            p.push_back(hdr0[8*j +: 8]);
         end
         p.push_back(id0);
         append_frame(mhfr_pkg::KIND_CONTROL, hdr0[7:0], p, 1'b0);
      end
      if ($urandom_range(0, 1)) begin
         n = frame_buf.size();
         frame_buf[n-2] = crc0[15:8];
         frame_buf[n-1] = crc0[7:0];
      end
   endfunction

   task automatic send_byte(logic [7:0] b);
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_buf();
      while (frame_buf.size() > 0) begin
         send_byte(frame_buf.pop_front());
      end
   endtask

   task automatic send_random_piece();
      int          r;
      int          kind;
      int          mode;
      logic [7:0]  id;
      logic [31:0] hdr;
      r = $urandom_range(0, 99);
      kind = $urandom_range(0, mhfr_pkg::KIND_COUNT - 1);
      hdr = mhfr_pkg::HEADER_WORD[kind];
      if (r < 55) begin
         mode = $urandom_range(0, 9);
         id = sb.device_id;
         if (mode >= 8) begin
            id = sb.device_id ^ 8'($urandom_range(1, 255));
         end
         append_frame(kind, id, random_payload(mhfr_pkg::FRAME_LEN[kind] - 7),
                      mode == 6 || mode == 7);
      end else if (r < 65) begin
         append_overlap();
      end else if (r < 80) begin
         frame_buf = random_payload($urandom_range(1, 6));
      end else if (r < 90) begin
         for (int j = 0; j < $urandom_range(1, 3); j++) begin
            frame_buf.push_back(hdr[8*j +: 8]);
         end
         frame_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         // Cut-off frame: the matcher keeps counting into whatever follows.
         append_frame(kind, sb.device_id, random_payload(mhfr_pkg::FRAME_LEN[kind] - 7),
                      1'b0);
         repeat ($urandom_range(1, mhfr_pkg::FRAME_LEN[kind] - 4)) begin
            void'(frame_buf.pop_back());
         end
      end
      send_buf();
   endtask

   task automatic run_mix(int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         send_random_piece();
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.write_register(addr / 4, data);
      @(posedge clock);
   endtask

   // Result side: checks every transaction and inserts random or long stalls.
   initial begin
      int stall_left;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_frame_kind, rsp_frame_status, rsp_last_of_run);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 4);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_multi_header_frame_receiver_crc16_core: errors");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Broken header: the second 0xAB must not restart the status request header.
      frame_buf = '{8'hAB, 8'hAB, 8'hAD, 8'hBA, 8'hBE, 8'h00, 8'hFF};
      append_frame(mhfr_pkg::KIND_STATUS_REQ, sb.device_id, random_payload(0), 1'b0);
      append_frame(mhfr_pkg::KIND_STATUS_REQ, 8'h7F, random_payload(0), 1'b0);
      append_frame(mhfr_pkg::KIND_STATUS_REQ, sb.device_id, random_payload(0), 1'b1);
      send_buf();

      sender_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      repeat (2) begin
         append_overlap();
         send_buf();
      end
      run_mix(MIX_BYTES);

      quiesce();
      csr_write(ADDR_DEVICE_ID, 32'h0000_0000);
      run_mix(MIX_BYTES);

      quiesce();
      csr_write(ADDR_UNMAPPED, $urandom);
      csr_write(ADDR_DEVICE_ID, ($urandom & 32'hFFFF_FF00) | 32'h0000_00FF);
      // Long result stall while frames keep coming, so the result queue fills.
      sender_idle_on = 1'b0;
      hold_off_request = 1'b1;
      repeat (6) begin
         append_frame(mhfr_pkg::KIND_STATUS_REQ, sb.device_id, random_payload(0), 1'b0);
      end
      send_buf();
      sender_idle_on = 1'b1;
      run_mix(MIX_BYTES);

      quiesce();
      csr_write(ADDR_DEVICE_ID, $urandom);
      run_mix(MIX_BYTES);

      quiesce();
      csr_write(ADDR_DEVICE_ID, $urandom);
      sender_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      while (bytes_sent < ITEM_TARGET) begin
         send_random_piece();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("tb_multi_header_frame_receiver_crc16_core: clean");
      end else begin
         $display("tb_multi_header_frame_receiver_crc16_core: errors");
      end
      $finish;
   end

endmodule

>>> multi_header_frame_receiver_crc16_core.f
+incdir+design
design/mhfr_pkg.sv
design/multi_header_frame_receiver_crc16_core.sv
tb/sv/tb_multi_header_frame_receiver_crc16_core.sv
